@@ rtl/apq_pkg.sv @@
// Shared types and codes for the array priority queue.
package apq_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_DEQUEUE = 1'b1
    } req_t;

    typedef struct packed {
        logic write_in;   // store the incoming word here
        logic take_next;  // load the entry of the next cell
        logic occupied;   // this cell holds a live entry
        logic lead;       // first cell: start the search token
    } cell_ctrl_t;

endpackage

@@ rtl/array_priority_queue_unit.sv @@
// Top level of the array priority queue: cell chain and request control.
//
// Usage:
//   Raise start with req_type, item_value and item_priority; the word is
//   taken at a rising edge where start is high and busy is low.
//   Each request gives exactly one result word: done is high for one
//   cycle with out_value, out_priority, status and fill_level.
//   The receiver cannot stall; results must be taken as they appear.
// Throughput:
//   Enqueue, overflow and empty dequeue: result in the cycle after accept,
//   busy stays low, so one such request per cycle while no search runs.
//   Dequeue of a live entry: a search token walks the chain of
//   QUEUE_DEPTH cells, one cell per cycle; busy stays high, and no
//   request is taken, until the result is registered.
//   The gap closes in the same edge as the result is registered, with
//   the winner's cell and the cells behind it loading their neighbors.
// Reset:
//   rst_n clears the fill count, the control state and the strobe;
//   the queue comes up empty. Entry storage is not cleared.
module array_priority_queue_unit #(
    parameter int QUEUE_DEPTH   = 8,
    parameter int PRIORITY_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic signed [31:0] item_value,
    input  logic [7:0]         item_priority,
    output logic               done,
    output logic signed [31:0] out_value,
    output logic [7:0]         out_priority,
    output logic [1:0]         status,
    output logic [3:0]         fill_level
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int FW = (CW > 4) ? CW : 4;
    localparam int PW = (PRIORITY_BITS > 8) ? PRIORITY_BITS : 8;
    localparam int VW = apq_pkg::VALUE_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    done_reg, done_next;
    logic [VW-1:0]           value_reg, value_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    apq_pkg::status_t        status_reg, status_next;
    logic [3:0]              fill_reg, fill_next;

    logic                    accept;
    logic                    enq_ok;
    logic                    inject;
    logic [PW-1:0]           prio_in_ext;
    logic [PRIORITY_BITS-1:0] prio_in;
    logic [PW-1:0]           prio_out_ext;
    logic [FW-1:0]           count_ext;

    apq_pkg::cell_ctrl_t     ctrl    [QUEUE_DEPTH];
    logic [VW-1:0]           c_value [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] c_prio [QUEUE_DEPTH];
    logic                    t_valid [QUEUE_DEPTH];
    logic [VW-1:0]           t_value [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] t_prio [QUEUE_DEPTH];
    logic [IW-1:0]           t_idx   [QUEUE_DEPTH];

    logic                    last_valid;
    logic [IW-1:0]           best_idx;

    assign busy        = (state_reg == S_SCAN);
    assign accept      = start && !busy;
    assign enq_ok      = accept && (req_type == apq_pkg::REQ_ENQUEUE)
                         && (count_reg < CW'(QUEUE_DEPTH));
    assign inject      = accept && (req_type == apq_pkg::REQ_DEQUEUE)
                         && (count_reg != '0);
    assign prio_in_ext = PW'(item_priority);
    assign prio_in     = prio_in_ext[PRIORITY_BITS-1:0];
    assign last_valid  = t_valid[QUEUE_DEPTH-1];
    assign best_idx    = t_idx[QUEUE_DEPTH-1];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [VW-1:0]            nbv;
            logic [PRIORITY_BITS-1:0] nbp;
            logic                     tiv;
            logic [VW-1:0]            tivl;
            logic [PRIORITY_BITS-1:0] tip;
            logic [IW-1:0]            tii;

            assign ctrl[gi].write_in  = enq_ok && (count_reg == CW'(gi));
            assign ctrl[gi].take_next = last_valid && (IW'(gi) >= best_idx)
                                        && (CW'(gi + 1) < count_reg);
            assign ctrl[gi].occupied  = (CW'(gi) < count_reg);
            assign ctrl[gi].lead      = (gi == 0);

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nbv = '0;
                assign nbp = '0;
            end
            else
            begin : g_body
                assign nbv = c_value[gi + 1];
                assign nbp = c_prio[gi + 1];
            end

            if (gi == 0)
            begin : g_head
                assign tiv  = inject;
                assign tivl = '0;
                assign tip  = '0;
                assign tii  = '0;
            end
            else
            begin : g_link
                assign tiv  = t_valid[gi - 1];
                assign tivl = t_value[gi - 1];
                assign tip  = t_prio[gi - 1];
                assign tii  = t_idx[gi - 1];
            end

            apq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .IDX_BITS      (IW),
                .CELL_INDEX    (gi)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl[gi]),
                .in_value      (item_value),
                .in_prio       (prio_in),
                .nb_value      (nbv),
                .nb_prio       (nbp),
                .tok_in_valid  (tiv),
                .tok_in_value  (tivl),
                .tok_in_prio   (tip),
                .tok_in_idx    (tii),
                .value         (c_value[gi]),
                .prio          (c_prio[gi]),
                .tok_out_valid (t_valid[gi]),
                .tok_out_value (t_value[gi]),
                .tok_out_prio  (t_prio[gi]),
                .tok_out_idx   (t_idx[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        prio_next   = prio_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next  = 1'b1;
                    value_next = '0;
                    prio_next  = '0;
                    if (req_type == apq_pkg::REQ_ENQUEUE)
                    begin
                        if (enq_ok)
                        begin
                            count_next  = count_reg + CW'(1);
                            status_next = apq_pkg::ST_ENQUEUED;
                        end
                        else
                        begin
                            status_next = apq_pkg::ST_OVERFLOW;
                        end
                    end
                    else if (inject)
                    begin
                        // hold the result until the token leaves the chain
                        done_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        status_next = apq_pkg::ST_EMPTY;
                    end
                end
            end
            S_SCAN:
            begin
                if (last_valid)
                begin
                    done_next   = 1'b1;
                    value_next  = t_value[QUEUE_DEPTH-1];
                    prio_next   = t_prio[QUEUE_DEPTH-1];
                    status_next = apq_pkg::ST_DEQUEUED;
                    count_next  = count_reg - CW'(1);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        count_ext = FW'(count_next);
        fill_next = done_next ? count_ext[3:0] : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    assign prio_out_ext = PW'(prio_reg);
    assign done         = done_reg;
    assign out_value    = signed'(value_reg);
    assign out_priority = prio_out_ext[7:0];
    assign status       = status_reg;
    assign fill_level   = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == apq_pkg::REQ_ENQUEUE)) |=> done)
        else $error("enqueue gave no result in the next cycle");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && (status_reg == apq_pkg::ST_DEQUEUED)))
        else $error("search ended without a dequeue result");

    a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == apq_pkg::REQ_DEQUEUE) && (count_reg == '0))
        |=> (done && (status_reg == apq_pkg::ST_EMPTY) && !busy))
        else $error("empty dequeue mishandled");

endmodule

@@ rtl/apq_cell.sv @@
// One queue cell: entry storage plus one stage of the max-search chain.
module apq_cell #(
    parameter int PRIORITY_BITS = 8,
    parameter int IDX_BITS      = 3,
    parameter int CELL_INDEX    = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  apq_pkg::cell_ctrl_t          ctrl,
    input  logic [apq_pkg::VALUE_W-1:0]  in_value,
    input  logic [PRIORITY_BITS-1:0]     in_prio,
    input  logic [apq_pkg::VALUE_W-1:0]  nb_value,
    input  logic [PRIORITY_BITS-1:0]     nb_prio,
    input  logic                         tok_in_valid,
    input  logic [apq_pkg::VALUE_W-1:0]  tok_in_value,
    input  logic [PRIORITY_BITS-1:0]     tok_in_prio,
    input  logic [IDX_BITS-1:0]          tok_in_idx,
    output logic [apq_pkg::VALUE_W-1:0]  value,
    output logic [PRIORITY_BITS-1:0]     prio,
    output logic                         tok_out_valid,
    output logic [apq_pkg::VALUE_W-1:0]  tok_out_value,
    output logic [PRIORITY_BITS-1:0]     tok_out_prio,
    output logic [IDX_BITS-1:0]          tok_out_idx
);

    logic [apq_pkg::VALUE_W-1:0] value_reg;
    logic [PRIORITY_BITS-1:0]    prio_reg;
    logic                        tok_valid_reg;
    logic [apq_pkg::VALUE_W-1:0] tok_value_reg;
    logic [PRIORITY_BITS-1:0]    tok_prio_reg;
    logic [IDX_BITS-1:0]         tok_idx_reg;
    logic                        take_own;

    // Strictly greater keeps the earliest entry among equal priorities.
    assign take_own = ctrl.occupied && (ctrl.lead || (prio_reg > tok_in_prio));

    always_ff @(posedge clk)
    begin
        if (ctrl.write_in)
        begin
            value_reg <= in_value;
            prio_reg  <= in_prio;
        end
        else if (ctrl.take_next)
        begin
            value_reg <= nb_value;
            prio_reg  <= nb_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in_valid)
        begin
            if (take_own)
            begin
                tok_value_reg <= value_reg;
                tok_prio_reg  <= prio_reg;
                tok_idx_reg   <= IDX_BITS'(CELL_INDEX);
            end
            else
            begin
                tok_value_reg <= tok_in_value;
                tok_prio_reg  <= tok_in_prio;
                tok_idx_reg   <= tok_in_idx;
            end
        end
    end

    assign value         = value_reg;
    assign prio          = prio_reg;
    assign tok_out_valid = tok_valid_reg;
    assign tok_out_value = tok_value_reg;
    assign tok_out_prio  = tok_prio_reg;
    assign tok_out_idx   = tok_idx_reg;

endmodule
